FILE: hw/rtl/csc_pkg.sv
// Shared types and constants for the compressed-sparse-column element store.
// Used by csc_col_store and the core module; depends on nothing.
package csc_pkg;

  localparam int unsigned MaxRows    = 256;
  localparam int unsigned MaxCols    = 256;
  localparam int unsigned MaxEntries = 1024;

  localparam int unsigned RowW   = $clog2(MaxRows);
  localparam int unsigned ColW   = $clog2(MaxCols);
  localparam int unsigned EntAw  = $clog2(MaxEntries);
  localparam int unsigned PtrW   = EntAw + 1;
  localparam int unsigned CntW   = 9;
  localparam int unsigned SizeW  = 9;
  localparam int unsigned ValW   = 64;
  localparam int unsigned EntW   = RowW + ValW;
  localparam int unsigned ColRecW = PtrW + CntW;

  localparam logic [2:0] StsHit   = 3'd0;
  localparam logic [2:0] StsMiss  = 3'd1;
  localparam logic [2:0] StsIns   = 3'd2;
  localparam logic [2:0] StsRange = 3'd3;
  localparam logic [2:0] StsFull  = 3'd4;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  localparam logic CfgRows = 1'b0;
  localparam logic CfgCols = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [RowW-1:0] row;
    logic [ColW-1:0] column;
    logic [ValW-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic [ValW-1:0] read_value;
    logic [2:0]      status;
  } rsp_t;

  typedef struct packed {
    logic [PtrW-1:0] start;
    logic [CntW-1:0] count;
  } col_t;

  typedef struct packed {
    logic            we;
    logic [ColW-1:0] waddr;
    col_t            wdata;
    logic [ColW-1:0] raddr;
  } col_req_t;

  typedef enum logic [3:0] {
    StIdle, StColWait, StScanRd, StScanChk, StDecide,
    StShiftRd, StShiftWr, StInsWr, StSweepRd, StSweepWr, StDone
  } state_e;

endpackage

FILE: hw/rtl/csc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module csc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/csc_col_store.sv
// Column pointer and count memory with per-column valid bits so reset reads as empty.
// Depends on csc_pkg and csc_ram.
module csc_col_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csc_pkg::col_req_t req_i,
  output csc_pkg::col_t     rdata_o
);

  logic [csc_pkg::MaxCols-1:0] valid_q;
  logic                        rvalid_q;
  logic [csc_pkg::ColRecW-1:0] ram_rdata;

  csc_ram #(
    .Width(csc_pkg::ColRecW),
    .Depth(csc_pkg::MaxCols)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.we),
    .waddr_i(req_i.waddr),
    .wdata_i(req_i.wdata),
    .raddr_i(req_i.raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      rvalid_q <= valid_q[req_i.raddr];
    end
  end

  assign rdata_o = rvalid_q ? csc_pkg::col_t'(ram_rdata) : '0;

endmodule

FILE: hw/rtl/csc_sparse_element_store_core.sv
// Top level of the compressed-sparse-column element store: request FSM and entry memory.
// Depends on csc_pkg, csc_ram and csc_col_store.
//
// Usage:
// Requests enter on in_valid_i / in_stall_o with payload in_req_i; one response per
// request leaves on out_valid_o / out_stall_i with payload out_rsp_o.
// One request is worked on at a time; in_stall_o is high while it is in progress.
// An out-of-range request goes straight to the response. Otherwise the column record
// is read and the column's entries are scanned in row order; a hit ends the scan, and
// a miss or a refusal when full is decided after it. An insert then shifts each later
// entry up one place, writes the new entry and the column record, and adds one to the
// start pointer of every column after the addressed one. Each step is one read and one
// write of the single-ported-per-side entry or column memory, with registered reads.
// The response sits in an output register; the next request is taken while it
// waits, and a finished request holds until that register is free.
// Reset empties the store (per-column valid bits, no clearing pass) and sets
// both size registers to 256. Configuration writes (cfg_valid_i, cfg_ready_o,
// cfg_index_i, cfg_data_i) are always accepted: index 0 rows, 1 columns.
module csc_sparse_element_store_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  csc_pkg::req_t              in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output csc_pkg::rsp_t              out_rsp_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [csc_pkg::SizeW-1:0]  cfg_data_i
);

  csc_pkg::state_e state_q, state_d;
  csc_pkg::req_t   req_q, req_d;
  csc_pkg::rsp_t   res_q, res_d, out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [csc_pkg::PtrW-1:0] start_q, start_d, end_q, end_d, k_q, k_d, pos_q, pos_d;
  logic [csc_pkg::PtrW-1:0] total_q, total_d;
  logic [csc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [csc_pkg::ColW-1:0] sweep_q, sweep_d;
  logic [csc_pkg::SizeW-1:0] rows_q, cols_q;

  csc_pkg::col_req_t col_req;
  csc_pkg::col_t     col_rd;
  logic                       ent_we;
  logic [csc_pkg::EntAw-1:0]  ent_waddr, ent_raddr;
  logic [csc_pkg::EntW-1:0]   ent_wdata, ent_rdata;
  logic [csc_pkg::RowW-1:0]   ent_row;
  logic [csc_pkg::ValW-1:0]   ent_val;

  logic in_acc, out_free, range_err;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != csc_pkg::StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign ent_row = ent_rdata[csc_pkg::EntW-1 -: csc_pkg::RowW];
  assign ent_val = ent_rdata[csc_pkg::ValW-1:0];
  assign range_err = ({1'b0, in_req_i.row} >= rows_q) || ({1'b0, in_req_i.column} >= cols_q);

  csc_ram #(
    .Width(csc_pkg::EntW),
    .Depth(csc_pkg::MaxEntries)
  ) u_ent_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  csc_col_store u_col_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (col_req),
    .rdata_o(col_rd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      csc_pkg::StIdle: begin
        if (in_acc) begin
          state_d = range_err ? csc_pkg::StDone : csc_pkg::StColWait;
        end
      end
      csc_pkg::StColWait: begin
        state_d = (col_rd.count == '0) ? csc_pkg::StDecide : csc_pkg::StScanRd;
      end
      csc_pkg::StScanRd: state_d = csc_pkg::StScanChk;
      csc_pkg::StScanChk: begin
        if (ent_row == req_q.row) begin
          state_d = csc_pkg::StDone;
        end else if (ent_row > req_q.row || k_q + 1'b1 == end_q) begin
          state_d = csc_pkg::StDecide;
        end else begin
          state_d = csc_pkg::StScanRd;
        end
      end
      csc_pkg::StDecide: begin
        if (req_q.operation == csc_pkg::OpRead ||
            total_q >= csc_pkg::PtrW'(csc_pkg::MaxEntries)) begin
          state_d = csc_pkg::StDone;
        end else if (total_q == pos_q) begin
          state_d = csc_pkg::StInsWr;
        end else begin
          state_d = csc_pkg::StShiftRd;
        end
      end
      csc_pkg::StShiftRd: state_d = csc_pkg::StShiftWr;
      csc_pkg::StShiftWr: begin
        state_d = (k_q - 1'b1 == pos_q) ? csc_pkg::StInsWr : csc_pkg::StShiftRd;
      end
      csc_pkg::StInsWr: begin
        state_d = (req_q.column == '1) ? csc_pkg::StDone : csc_pkg::StSweepRd;
      end
      csc_pkg::StSweepRd: state_d = csc_pkg::StSweepWr;
      csc_pkg::StSweepWr: begin
        state_d = (sweep_q == '1) ? csc_pkg::StDone : csc_pkg::StSweepRd;
      end
      csc_pkg::StDone: begin
        if (out_free) begin
          state_d = csc_pkg::StIdle;
        end
      end
      default: state_d = csc_pkg::StIdle;
    endcase
  end

  always_comb begin
    req_d = req_q;
    res_d = res_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    start_d = start_q;
    end_d = end_q;
    k_d = k_q;
    pos_d = pos_q;
    cnt_d = cnt_q;
    total_d = total_q;
    sweep_d = sweep_q;
    col_req = '0;
    col_req.raddr = req_q.column;
    ent_we = 1'b0;
    ent_waddr = '0;
    ent_wdata = {req_q.row, req_q.write_value};
    ent_raddr = '0;
    case (state_q)
      csc_pkg::StIdle: begin
        col_req.raddr = in_req_i.column;
        if (in_acc) begin
          req_d = in_req_i;
          res_d.read_value = '0;
          res_d.status = csc_pkg::StsRange;
        end
      end
      csc_pkg::StColWait: begin
        start_d = col_rd.start;
        cnt_d = col_rd.count;
        end_d = col_rd.start + csc_pkg::PtrW'(col_rd.count);
        pos_d = col_rd.start + csc_pkg::PtrW'(col_rd.count);
        k_d = col_rd.start;
      end
      csc_pkg::StScanRd: ent_raddr = k_q[csc_pkg::EntAw-1:0];
      csc_pkg::StScanChk: begin
        if (ent_row == req_q.row) begin
          res_d.status = csc_pkg::StsHit;
          if (req_q.operation == csc_pkg::OpWrite) begin
            ent_we = 1'b1;
            ent_waddr = k_q[csc_pkg::EntAw-1:0];
            res_d.read_value = req_q.write_value;
          end else begin
            res_d.read_value = ent_val;
          end
        end else if (ent_row > req_q.row) begin
          pos_d = k_q;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      csc_pkg::StDecide: begin
        res_d.read_value = '0;
        k_d = total_q;
        if (req_q.operation == csc_pkg::OpRead) begin
          res_d.status = csc_pkg::StsMiss;
        end else begin
          res_d.status = csc_pkg::StsFull;
        end
      end
      csc_pkg::StShiftRd: ent_raddr = k_q[csc_pkg::EntAw-1:0] - 1'b1;
      csc_pkg::StShiftWr: begin
        ent_we = 1'b1;
        ent_waddr = k_q[csc_pkg::EntAw-1:0];
        ent_wdata = ent_rdata;
        k_d = k_q - 1'b1;
      end
      csc_pkg::StInsWr: begin
        ent_we = 1'b1;
        ent_waddr = pos_q[csc_pkg::EntAw-1:0];
        col_req.we = 1'b1;
        col_req.waddr = req_q.column;
        col_req.wdata.start = start_q;
        col_req.wdata.count = cnt_q + 1'b1;
        total_d = total_q + 1'b1;
        sweep_d = req_q.column + 1'b1;
        res_d.read_value = req_q.write_value;
        res_d.status = csc_pkg::StsIns;
      end
      csc_pkg::StSweepRd: col_req.raddr = sweep_q;
      csc_pkg::StSweepWr: begin
        col_req.we = 1'b1;
        col_req.waddr = sweep_q;
        col_req.wdata.start = col_rd.start + 1'b1;
        col_req.wdata.count = col_rd.count;
        sweep_d = sweep_q + 1'b1;
      end
      csc_pkg::StDone: begin
        if (out_free) begin
          out_d = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csc_pkg::StIdle;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      rows_q      <= csc_pkg::SizeW'(csc_pkg::MaxRows);
      cols_q      <= csc_pkg::SizeW'(csc_pkg::MaxCols);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == csc_pkg::CfgRows) begin
          rows_q <= cfg_data_i;
        end else begin
          cols_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    res_q   <= res_d;
    out_q   <= out_d;
    start_q <= start_d;
    end_q   <= end_d;
    k_q     <= k_d;
    pos_q   <= pos_d;
    cnt_q   <= cnt_d;
    sweep_q <= sweep_d;
  end

endmodule
